// File: hdl/prt_pkg.sv
// Shared types and constants of the permission range table.
package prt_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 64;

    localparam int ADDR_W = 64;
    localparam int MODE_W = 8;
    localparam int MASK_W = 64;

    // Stored key is {start, end, mode}; stored masks are {hosts, processes}.
    localparam int KEY_W   = 2 * ADDR_W + MODE_W;
    localparam int MASKS_W = 2 * MASK_W;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [ADDR_W-1:0] range_start;
        logic [ADDR_W-1:0] range_end;
        logic [MODE_W-1:0] access_mode;
        logic [MASK_W-1:0] host_bits;
        logic [MASK_W-1:0] process_bits;
    } item_t;

    typedef struct packed {
        logic              matched;
        logic [5:0]        entry_index;
        logic [MASK_W-1:0] host_bits_after;
        logic [6:0]        entry_count;
        logic              table_full;
    } result_t;

endpackage

// File: hdl/prt_ifs.sv
// Valid/ready channel interfaces for items and results of the permission range table.
interface prt_item_if;
    logic            valid;
    logic            ready;
    prt_pkg::item_t  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface prt_result_if;
    logic             valid;
    logic             ready;
    prt_pkg::result_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: hdl/prt_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module prt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: hdl/permission_range_table_unit.sv
// Top level of the permission range table: sequencer over the key and mask memories.
//
// Usage: one valid/ready channel carries items in (insert/merge or remove host
// access) and one carries exactly one result per item out. An item is taken
// only while the unit is idle; the table is then scanned one entry per cycle,
// a read issued each cycle to the key and mask memories, whose registered data
// is compared, modified and written back in the cycle after the read.
// An insert scan stops at the first entry whose key matches and merges into it;
// any other item scans every used entry, and an insert with no match then appends
// a new entry unless the table is full. Entries are read one at a time through the
// single read port of the entry memories. One item is in work at a time, and the
// next one can be accepted once its result is loaded into the output register.
// The result sits in an output register; the next item is accepted while it
// waits. If the receiver stalls and a second result is ready, the unit holds
// it until the output register frees up.
// Reset empties the table by clearing the entry count; the memories are not
// cleared, and entries at or above the count are never read. No clearing
// pass is needed, so items are accepted right after reset.
module permission_range_table_unit #(
    parameter int TABLE_DEPTH = prt_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic         clk,
    input  logic         rst_n,
    prt_item_if.sink     item,
    prt_result_if.source result
);

    import prt_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    item_t             item_reg;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     rd_idx_reg, rd_idx_next;
    logic              chk_vld_reg, chk_vld_next;
    logic [AW-1:0]     chk_idx_reg, chk_idx_next;
    logic              found_reg, found_next;
    logic [AW-1:0]     first_idx_reg, first_idx_next;
    logic [MASK_W-1:0] first_hosts_reg, first_hosts_next;
    logic              full_reg, full_next;
    result_t           out_reg, out_next;
    logic              out_valid_reg, out_valid_next;

    logic               item_acc;
    logic               out_free;
    logic               scan_more;
    logic               is_insert;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic [KEY_W-1:0]   key_rd;
    logic [MASKS_W-1:0] mask_rd;
    logic               key_we;
    logic               mask_we;
    logic [AW-1:0]      wr_addr;
    logic [KEY_W-1:0]   key_wr;
    logic [MASKS_W-1:0] mask_wr;
    logic [ADDR_W-1:0]  ent_start;
    logic [ADDR_W-1:0]  ent_end;
    logic [MODE_W-1:0]  ent_mode;
    logic [MASK_W-1:0]  ent_hosts;
    logic [MASK_W-1:0]  ent_procs;
    logic               same_range;
    logic               same_key;
    logic [AW+5:0]      idx_wide;
    logic [CW+6:0]      count_wide;

    prt_ram #(
        .WIDTH (KEY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_key_ram (
        .clk     (clk),
        .wr_en   (key_we),
        .wr_addr (wr_addr),
        .wr_data (key_wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (key_rd)
    );

    prt_ram #(
        .WIDTH (MASKS_W),
        .DEPTH (TABLE_DEPTH)
    ) u_mask_ram (
        .clk     (clk),
        .wr_en   (mask_we),
        .wr_addr (wr_addr),
        .wr_data (mask_wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (mask_rd)
    );

    assign item.ready     = (state_reg == ST_IDLE);
    assign item_acc       = item.valid && item.ready;
    assign result.valid   = out_valid_reg;
    assign result.payload = out_reg;
    assign out_free       = !out_valid_reg || result.ready;

    assign scan_more = (rd_idx_reg != count_reg);
    assign rd_en     = (state_reg == ST_SCAN) && scan_more;
    assign rd_addr   = rd_idx_reg[AW-1:0];
    assign is_insert = (item_reg.kind == KIND_INSERT);

    assign ent_start = key_rd[KEY_W-1 -: ADDR_W];
    assign ent_end   = key_rd[MODE_W +: ADDR_W];
    assign ent_mode  = key_rd[MODE_W-1:0];
    assign ent_hosts = mask_rd[MASKS_W-1 -: MASK_W];
    assign ent_procs = mask_rd[MASK_W-1:0];

    assign same_range = (ent_start == item_reg.range_start) && (ent_end == item_reg.range_end);
    assign same_key   = same_range && (ent_mode == item_reg.access_mode);

    assign idx_wide   = {6'd0, first_idx_reg};
    assign count_wide = {7'd0, count_reg};

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        rd_idx_next      = rd_idx_reg;
        chk_vld_next     = 1'b0;
        chk_idx_next     = rd_idx_reg[AW-1:0];
        found_next       = found_reg;
        first_idx_next   = first_idx_reg;
        first_hosts_next = first_hosts_reg;
        full_next        = full_reg;
        out_next         = out_reg;
        out_valid_next   = out_valid_reg;
        key_we           = 1'b0;
        mask_we          = 1'b0;
        wr_addr          = chk_idx_reg;
        key_wr           = {item_reg.range_start, item_reg.range_end, item_reg.access_mode};
        mask_wr          = {ent_hosts | item_reg.host_bits, ent_procs | item_reg.process_bits};

        if (result.valid && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (item_acc)
                begin
                    state_next       = ST_SCAN;
                    rd_idx_next      = '0;
                    found_next       = 1'b0;
                    first_idx_next   = '0;
                    first_hosts_next = '0;
                    full_next        = 1'b0;
                end
            end

            ST_SCAN:
            begin
                if (rd_en)
                begin
                    rd_idx_next  = rd_idx_reg + 1'b1;
                    chk_vld_next = 1'b1;
                end

                if (chk_vld_reg)
                begin
                    if (is_insert && same_key)
                    begin
                        // First matching entry takes the merge; the read already
                        // issued for the next entry is dropped.
                        mask_we          = 1'b1;
                        found_next       = 1'b1;
                        first_idx_next   = chk_idx_reg;
                        first_hosts_next = ent_hosts | item_reg.host_bits;
                        chk_vld_next     = 1'b0;
                        state_next       = ST_FINISH;
                    end
                    else if (!is_insert && same_range)
                    begin
                        mask_we = 1'b1;
                        mask_wr = {ent_hosts ^ item_reg.host_bits, ent_procs};
                        if (!found_reg)
                        begin
                            found_next       = 1'b1;
                            first_idx_next   = chk_idx_reg;
                            first_hosts_next = ent_hosts ^ item_reg.host_bits;
                        end
                    end
                end
                else if (!scan_more)
                begin
                    // Every valid entry has been checked without a merge.
                    if (is_insert)
                    begin
                        if (count_reg == CW'(TABLE_DEPTH))
                        begin
                            full_next = 1'b1;
                        end
                        else
                        begin
                            key_we           = 1'b1;
                            mask_we          = 1'b1;
                            wr_addr          = count_reg[AW-1:0];
                            mask_wr          = {item_reg.host_bits, item_reg.process_bits};
                            first_idx_next   = count_reg[AW-1:0];
                            first_hosts_next = item_reg.host_bits;
                            count_next       = count_reg + 1'b1;
                        end
                    end
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next           = 1'b1;
                    out_next.matched         = found_reg;
                    out_next.entry_index     = idx_wide[5:0];
                    out_next.host_bits_after = first_hosts_reg;
                    out_next.entry_count     = count_wide[6:0];
                    out_next.table_full      = full_reg;
                    state_next               = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            chk_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            chk_vld_reg   <= chk_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_acc)
        begin
            item_reg <= item.payload;
        end
        rd_idx_reg      <= rd_idx_next;
        chk_idx_reg     <= chk_idx_next;
        found_reg       <= found_next;
        first_idx_reg   <= first_idx_next;
        first_hosts_reg <= first_hosts_next;
        full_reg        <= full_next;
        out_reg         <= out_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("entry count exceeds table depth");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> (count_reg == $past(count_reg) + 1'b1))
        else $error("entry count changed by other than one");

    a_check_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        chk_vld_reg |-> $past(rd_en))
        else $error("compare without a preceding memory read");

    a_key_write_append: assert property (@(posedge clk) disable iff (!rst_n)
        key_we |-> (state_reg == ST_SCAN && is_insert && !chk_vld_reg && !scan_more))
        else $error("key memory written outside an append");

    a_full_at_depth: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && full_reg) |-> (count_reg == CW'(TABLE_DEPTH)))
        else $error("table full reported below depth");

endmodule
